>>> sv/cdn_pkg.sv
// Shared types, constants, microcode table and calendar helpers for the day number converter.
`timescale 1ns / 1ps

package cdn_pkg;

   localparam int YR_W           = 13;       // year counter, holds one past the last year
   localparam int ACC_W          = 20;       // day accumulator for the year and month sums
   localparam int DN_MAX         = 131071;
   localparam int YEAR_FIELD_MAX = 4095;
   localparam logic [3:0] MONTH_LAST = 4'd12;

   typedef struct packed {
      logic        mode;
      logic [11:0] in_year;
      logic [3:0]  in_month;
      logic [4:0]  in_day;
      logic [16:0] in_day_number;
   } req_type;

   typedef struct packed {
      logic [16:0] out_day_number;
      logic [11:0] out_year;
      logic [3:0]  out_month;
      logic [4:0]  out_day;
      logic [2:0]  weekday;
      logic        error;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_INIT,
      OP_ERR,
      OP_YEAR,
      OP_MONTH,
      OP_DAY,
      OP_DONE
   } op_type;

   typedef enum logic [2:0] {
      CND_ALWAYS,
      CND_BAD_INPUT,
      CND_YEAR_MORE,
      CND_YEAR_OVER,
      CND_BAD_DAY,
      CND_MONTH_MORE,
      CND_DN_BIG
   } cond_type;

   localparam int PC_W = 4;
   typedef logic [PC_W-1:0] pc_type;

   // step runs op and jumps to target when cond holds, else falls through
   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } uword_type;

   typedef struct packed {
      logic   load;
      op_type op;
   } dp_ctrl_type;

   typedef struct packed {
      logic bad_input;
      logic year_more;
      logic year_over;
      logic bad_day;
      logic month_more;
      logic dn_big;
   } dp_flags_type;

   localparam pc_type STEP_INIT   = 4'd0;
   localparam pc_type STEP_CHECK  = 4'd1;
   localparam pc_type STEP_YEARS  = 4'd2;
   localparam pc_type STEP_YOVER  = 4'd3;
   localparam pc_type STEP_DCHECK = 4'd4;
   localparam pc_type STEP_MONTHS = 4'd5;
   localparam pc_type STEP_DAY    = 4'd6;
   localparam pc_type STEP_RANGE  = 4'd7;
   localparam pc_type STEP_FIN    = 4'd8;

   function automatic uword_type ucode(pc_type pc);
      uword_type w;
      case (pc)
         STEP_INIT:   w = '{OP_INIT,  CND_ALWAYS,     STEP_CHECK};
         STEP_CHECK:  w = '{OP_ERR,   CND_BAD_INPUT,  STEP_FIN};
         STEP_YEARS:  w = '{OP_YEAR,  CND_YEAR_MORE,  STEP_YEARS};
         STEP_YOVER:  w = '{OP_ERR,   CND_YEAR_OVER,  STEP_FIN};
         STEP_DCHECK: w = '{OP_ERR,   CND_BAD_DAY,    STEP_FIN};
         STEP_MONTHS: w = '{OP_MONTH, CND_MONTH_MORE, STEP_MONTHS};
         STEP_DAY:    w = '{OP_DAY,   CND_ALWAYS,     STEP_RANGE};
         STEP_RANGE:  w = '{OP_ERR,   CND_DN_BIG,     STEP_FIN};
         STEP_FIN:    w = '{OP_DONE,  CND_ALWAYS,     STEP_INIT};
         default:     w = '{OP_NOP,   CND_ALWAYS,     STEP_FIN};
      endcase
      return w;
   endfunction

   localparam logic [4:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // zero for a month code outside 1..12
   function automatic logic [4:0] days_in_month(logic [3:0] m, logic leap);
      logic [4:0] r;
      if (m == 4'd0 || m > MONTH_LAST) begin
         r = 5'd0;
      end else if (m == 4'd2 && leap) begin
         r = 5'd29;
      end else begin
         r = MONTH_LEN[m - 4'd1];
      end
      return r;
   endfunction

   function automatic logic [2:0] mod7(logic [5:0] v);
      logic [5:0] r;
      r = v;
      if (r >= 6'd56) r = r - 6'd56;
      if (r >= 6'd28) r = r - 6'd28;
      if (r >= 6'd14) r = r - 6'd14;
      if (r >= 6'd7)  r = r - 6'd7;
      return r[2:0];
   endfunction

endpackage

>>> sv/cdn_datapath.sv
// Year/month walking datapath driven by the microcode sequencer.
`timescale 1ns / 1ps

module cdn_datapath #(
   parameter int BASE_YEAR = 1900,
   parameter int YEAR_SPAN = 256
) (
   input  logic                 clock,
   input  cdn_pkg::dp_ctrl_type ctrl,
   input  cdn_pkg::req_type     req_word,
   output cdn_pkg::dp_flags_type flags,
   output cdn_pkg::rsp_type     result
);
   import cdn_pkg::*;

   localparam int LAST_RAW  = BASE_YEAR + YEAR_SPAN - 1;
   localparam int LAST_INT  = (LAST_RAW > YEAR_FIELD_MAX) ? YEAR_FIELD_MAX : LAST_RAW;
   localparam int PRIOR     = BASE_YEAR - 1;
   localparam int JAN1_WD   = (PRIOR + PRIOR / 4 - PRIOR / 100 + PRIOR / 400 + 1) % 7;
   localparam int BASE_C100 = BASE_YEAR % 100;
   localparam int BASE_C400 = BASE_YEAR % 400;

   localparam logic [YR_W-1:0] BASE_Y = YR_W'(BASE_YEAR);
   localparam logic [YR_W-1:0] LAST_Y = YR_W'(LAST_INT);

   req_type          req_ff;
   logic [YR_W-1:0]  year_ff;
   logic [3:0]       month_ff;
   logic [6:0]       c100_ff;
   logic [8:0]       c400_ff;
   logic [ACC_W-1:0] acc_ff;
   logic [2:0]       wd_ff;
   logic [4:0]       day_ff;
   logic             err_ff;

   logic             leap;
   logic [8:0]       year_len;
   logic [4:0]       dim_cur;
   logic [4:0]       dim_req;
   logic [YR_W-1:0]  req_year;
   logic [4:0]       day_pick;

   assign leap     = ((year_ff[1:0] == 2'd0) && (c100_ff != 7'd0)) || (c400_ff == 9'd0);
   assign year_len = leap ? 9'd366 : 9'd365;
   assign dim_cur  = days_in_month(month_ff, leap);
   assign dim_req  = days_in_month(req_ff.in_month, leap);
   assign req_year = {1'b0, req_ff.in_year};
   assign day_pick = req_ff.mode ? acc_ff[4:0] : req_ff.in_day;

   always_comb begin
      if (req_ff.mode) begin
         flags.bad_input  = (req_ff.in_day_number == 17'd0);
         flags.year_more  = (year_ff <= LAST_Y) && (acc_ff > ACC_W'(year_len));
         flags.month_more = (month_ff < MONTH_LAST) && (acc_ff > ACC_W'(dim_cur));
      end else begin
         flags.bad_input  = (req_year < BASE_Y) || (req_year > LAST_Y) ||
                            (req_ff.in_month == 4'd0) || (req_ff.in_month > MONTH_LAST) ||
                            (req_ff.in_day == 5'd0);
         flags.year_more  = (year_ff != req_year);
         flags.month_more = (month_ff != req_ff.in_month);
      end
      flags.year_over = req_ff.mode && (year_ff > LAST_Y);
      flags.bad_day   = !req_ff.mode && (req_ff.in_day > dim_req);
      flags.dn_big    = !req_ff.mode && (acc_ff > ACC_W'(DN_MAX));
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         req_ff <= req_word;
      end
      case (ctrl.op)
         OP_INIT: begin
            year_ff  <= BASE_Y;
            month_ff <= 4'd1;
            c100_ff  <= 7'(BASE_C100);
            c400_ff  <= 9'(BASE_C400);
            wd_ff    <= 3'(JAN1_WD);
            acc_ff   <= req_ff.mode ? ACC_W'(req_ff.in_day_number) : '0;
            err_ff   <= 1'b0;
         end
         OP_ERR: begin
            err_ff <= 1'b1;
         end
         OP_YEAR: begin
            acc_ff  <= req_ff.mode ? acc_ff - ACC_W'(year_len) : acc_ff + ACC_W'(year_len);
            year_ff <= year_ff + 1'b1;
            c100_ff <= (c100_ff == 7'd99) ? 7'd0 : c100_ff + 7'd1;
            c400_ff <= (c400_ff == 9'd399) ? 9'd0 : c400_ff + 9'd1;
            // 365 days move the weekday by one, 366 by two
            wd_ff   <= mod7(6'(wd_ff) + (leap ? 6'd2 : 6'd1));
         end
         OP_MONTH: begin
            acc_ff   <= req_ff.mode ? acc_ff - ACC_W'(dim_cur) : acc_ff + ACC_W'(dim_cur);
            month_ff <= month_ff + 4'd1;
            wd_ff    <= mod7(6'(wd_ff) + 6'(dim_cur));
         end
         OP_DAY: begin
            day_ff <= day_pick;
            if (!req_ff.mode) begin
               acc_ff <= acc_ff + ACC_W'(req_ff.in_day);
            end
            wd_ff <= mod7(6'(wd_ff) + 6'(day_pick) - 6'd1);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result = '0;
      if (err_ff) begin
         result.error = 1'b1;
      end else begin
         result.out_day_number = req_ff.mode ? req_ff.in_day_number : acc_ff[16:0];
         result.out_year       = req_ff.mode ? year_ff[11:0] : req_ff.in_year;
         result.out_month      = req_ff.mode ? month_ff : req_ff.in_month;
         result.out_day        = day_ff;
         result.weekday        = wd_ff;
      end
   end

endmodule

>>> sv/calendar_day_number_converter.sv
// Top level: microcode sequencer and command handshake of the day number converter.
`timescale 1ns / 1ps
// Steps from accept: init, input check, year walk at one year a cycle, year range check,
// day check, month walk, day step, day number range check and finish, which registers the
// result and sets rsp_strobe. Bad input jumps from the input check to finish. One word at
// a time; busy is high while it runs. A new word may start the cycle rsp_strobe is high.
// Synchronous active-high reset idles the sequencer; no clearing pass. Results cannot stall.

module calendar_day_number_converter #(
   parameter int BASE_YEAR = 1900,
   parameter int YEAR_SPAN = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  cdn_pkg::req_type req_word,
   output logic             busy,
   output logic             rsp_strobe,
   output cdn_pkg::rsp_type rsp_word
);
   import cdn_pkg::*;

   logic         busy_ff;
   pc_type       pc_ff;
   logic         rsp_strobe_ff;
   rsp_type      rsp_ff;

   logic         accept;
   uword_type    uword;
   logic         cond_hit;
   dp_ctrl_type  ctrl;
   dp_flags_type flags;
   rsp_type      dp_result;

   assign accept = start && !busy_ff;
   assign uword  = ucode(pc_ff);

   always_comb begin
      case (uword.cond)
         CND_ALWAYS:     cond_hit = 1'b1;
         CND_BAD_INPUT:  cond_hit = flags.bad_input;
         CND_YEAR_MORE:  cond_hit = flags.year_more;
         CND_YEAR_OVER:  cond_hit = flags.year_over;
         CND_BAD_DAY:    cond_hit = flags.bad_day;
         CND_MONTH_MORE: cond_hit = flags.month_more;
         CND_DN_BIG:     cond_hit = flags.dn_big;
         default:        cond_hit = 1'b0;
      endcase
   end

   assign ctrl.load = accept;
   assign ctrl.op   = (busy_ff && cond_hit) ? uword.op : OP_NOP;

   cdn_datapath #(
      .BASE_YEAR (BASE_YEAR),
      .YEAR_SPAN (YEAR_SPAN)
   ) u_datapath (
      .clock    (clock),
      .ctrl     (ctrl),
      .req_word (req_word),
      .flags    (flags),
      .result   (dp_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         pc_ff         <= STEP_INIT;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (accept) begin
            busy_ff <= 1'b1;
            pc_ff   <= STEP_INIT;
         end else if (busy_ff) begin
            if (cond_hit) begin
               pc_ff <= uword.target;
               if (uword.op == OP_DONE) begin
                  busy_ff       <= 1'b0;
                  rsp_strobe_ff <= 1'b1;
               end
            end else begin
               pc_ff <= pc_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.op == OP_DONE) begin
         rsp_ff <= dp_result;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> !busy_ff)
      else $error("result strobe while sequencer busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff && (pc_ff == STEP_INIT))
      else $error("accepted word did not start the program");

   a_idle_pc: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (pc_ff == STEP_INIT))
      else $error("step counter moved while idle");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.error) |->
         (rsp_ff.out_day_number == 17'd0) && (rsp_ff.out_year == 12'd0) &&
         (rsp_ff.weekday == 3'd0))
      else $error("error result carries nonzero fields");

   a_good_date: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_ff.error) |->
         (rsp_ff.out_month != 4'd0) && (rsp_ff.out_month <= MONTH_LAST) &&
         (rsp_ff.out_day != 5'd0) && (rsp_ff.out_day_number != 17'd0))
      else $error("good result with out-of-range date");

endmodule

>>> tb/calendar_day_number_converter_tb.sv
// Self-checking testbench for the calendar day number converter: directed and random words.
`timescale 1ns / 1ps

module calendar_day_number_converter_tb;
   import cdn_pkg::*;

   localparam int FIRST_YEAR   = 1900;
   localparam int YEAR_COUNT   = 256;
   localparam int SPAN_END     = FIRST_YEAR + YEAR_COUNT - 1;
   localparam int FINAL_YEAR   = (SPAN_END > YEAR_FIELD_MAX) ? YEAR_FIELD_MAX : SPAN_END;
   localparam int RANDOM_WORDS = 1700;
   localparam int IDLE_PCT     = 23;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = YEAR_COUNT + 40;
   localparam int REPORT_MAX   = 10;

   localparam logic MODE_TO_NUMBER = 1'b0;
   localparam logic MODE_TO_DATE   = 1'b1;

   localparam int WEEKDAY_OFFSET [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_word = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_word;

   req_type request_words [$];
   rsp_type predicted_conversions [$];
   int      words_sent = 0;
   int      errors = 0;
   int      stall_cycles = 0;
   int      last_day_number;

   calendar_day_number_converter #(
      .BASE_YEAR(FIRST_YEAR),
      .YEAR_SPAN(YEAR_COUNT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_word(req_word),
      .busy(busy),
      .rsp_strobe(rsp_strobe),
      .rsp_word(rsp_word)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit leap_year(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int year_length(int y);
      return leap_year(y) ? 366 : 365;
   endfunction

   function automatic int month_length(int m, int y);
      int n;
      case (m)
         2: n = leap_year(y) ? 29 : 28;
         4, 6, 9, 11: n = 30;
         1, 3, 5, 7, 8, 10, 12: n = 31;
         default: n = 0;
      endcase
      return n;
   endfunction

   function automatic rsp_type convert_calendar(req_type w);
      rsp_type r;
      int y, m, d, dn, rem, wy;
      bit bad;
      r = '0;
      bad = 1'b0;
      y = 0;
      m = 0;
      d = 0;
      dn = 0;
      if (w.mode == MODE_TO_NUMBER) begin
         y = int'(w.in_year);
         m = int'(w.in_month);
         d = int'(w.in_day);
         if (y < FIRST_YEAR || y > FINAL_YEAR || m < 1 || m > 12 || d < 1 ||
             d > month_length(m, y)) begin
            bad = 1'b1;
         end else begin
            for (int i = FIRST_YEAR; i < y; i++) dn += year_length(i);
            for (int i = 1; i < m; i++) dn += month_length(i, y);
            dn += d;
            if (dn > DN_MAX) bad = 1'b1;
         end
      end else begin
         dn = int'(w.in_day_number);
         rem = dn;
         if (rem == 0) begin
            bad = 1'b1;
         end else begin
            y = FIRST_YEAR;
            while (y <= FINAL_YEAR && rem > year_length(y)) begin
               rem -= year_length(y);
               y++;
            end
            if (y > FINAL_YEAR) begin
               bad = 1'b1;
            end else begin
               m = 1;
               while (m < 12 && rem > month_length(m, y)) begin
                  rem -= month_length(m, y);
                  m++;
               end
               d = rem;
            end
         end
      end
      if (bad) begin
         r.error = 1'b1;
      end else begin
         // Jan and Feb count as months of the previous year for the weekday
         wy = (m < 3) ? y - 1 : y;
         r.out_day_number = dn[16:0];
         r.out_year       = y[11:0];
         r.out_month      = m[3:0];
         r.out_day        = d[4:0];
         r.weekday        = 3'((wy + wy / 4 - wy / 100 + wy / 400 + WEEKDAY_OFFSET[m - 1] + d) % 7);
      end
      return r;
   endfunction

   // unused fields of the other mode carry random junk
   function automatic req_type date_word(int y, int m, int d);
      req_type w;
      w.mode          = MODE_TO_NUMBER;
      w.in_year       = y[11:0];
      w.in_month      = m[3:0];
      w.in_day        = d[4:0];
      w.in_day_number = 17'($urandom);
      return w;
   endfunction

   function automatic req_type number_word(int dn);
      req_type w;
      w               = req_type'({$urandom, $urandom});
      w.mode          = MODE_TO_DATE;
      w.in_day_number = dn[16:0];
      return w;
   endfunction

   // driver: start stays high until the word is taken, then the next one follows
   always @(posedge clock) begin
      bit taken;
      bit quiet;
      taken = 1'b0;
      quiet = (words_sent >= 700 && words_sent < 1000);
      if (!reset) begin
         if (start && !busy) begin
            predicted_conversions.push_back(convert_calendar(req_word));
            taken = 1'b1;
         end
         if (!start || taken) begin
            if (request_words.size() != 0 &&
                (quiet || $urandom_range(99) >= IDLE_PCT)) begin
               req_word <= request_words.pop_front();
               start <= 1'b1;
               words_sent <= words_sent + 1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: each strobed word is checked against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (predicted_conversions.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("unexpected result word at %0t: dn=%0d %0d-%0d-%0d wd=%0d err=%0b",
                        $realtime, rsp_word.out_day_number, rsp_word.out_year,
                        rsp_word.out_month, rsp_word.out_day, rsp_word.weekday,
                        rsp_word.error);
         end else begin
            want = predicted_conversions.pop_front();
            if (rsp_word.out_day_number !== want.out_day_number ||
                rsp_word.out_year !== want.out_year ||
                rsp_word.out_month !== want.out_month ||
                rsp_word.out_day !== want.out_day ||
                rsp_word.weekday !== want.weekday ||
                rsp_word.error !== want.error) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display("mismatch at %0t: expected dn=%0d %0d-%0d-%0d wd=%0d err=%0b, got dn=%0d %0d-%0d-%0d wd=%0d err=%0b",
                           $realtime, want.out_day_number, want.out_year, want.out_month,
                           want.out_day, want.weekday, want.error,
                           rsp_word.out_day_number, rsp_word.out_year, rsp_word.out_month,
                           rsp_word.out_day, rsp_word.weekday, rsp_word.error);
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int y, m, pick;
      last_day_number = int'(convert_calendar(date_word(FINAL_YEAR, 12, 31)).out_day_number);

      // directed: span edges, leap rules, bad fields, day number edges
      request_words.push_back(date_word(FIRST_YEAR, 1, 1));
      request_words.push_back(date_word(FINAL_YEAR, 12, 31));
      request_words.push_back(date_word(2000, 2, 29));
      request_words.push_back(date_word(1900, 2, 29));
      request_words.push_back(date_word(2004, 2, 29));
      request_words.push_back(date_word(2001, 2, 29));
      request_words.push_back(date_word(FIRST_YEAR - 1, 12, 31));
      request_words.push_back(date_word(FINAL_YEAR + 1, 1, 1));
      request_words.push_back(date_word(YEAR_FIELD_MAX, 15, 31));
      request_words.push_back(date_word(0, 0, 0));
      request_words.push_back(date_word(2020, 0, 10));
      request_words.push_back(date_word(2020, 13, 10));
      request_words.push_back(date_word(2020, 5, 0));
      request_words.push_back(date_word(2020, 4, 31));
      request_words.push_back(date_word(2020, 12, 31));
      request_words.push_back(number_word(0));
      request_words.push_back(number_word(1));
      request_words.push_back(number_word(59));
      request_words.push_back(number_word(60));
      request_words.push_back(number_word(365));
      request_words.push_back(number_word(366));
      request_words.push_back(number_word(last_day_number));
      request_words.push_back(number_word(last_day_number + 1));
      request_words.push_back(number_word(DN_MAX));

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            y = $urandom_range(FINAL_YEAR, FIRST_YEAR);
            m = $urandom_range(12, 1);
            request_words.push_back(date_word(y, m, $urandom_range(month_length(m, y), 1)));
         end else if (pick < 80) begin
            request_words.push_back(number_word($urandom_range(last_day_number, 1)));
         end else if (pick < 90) begin
            request_words.push_back(date_word($urandom_range(FINAL_YEAR + 2, FIRST_YEAR - 2),
                                              $urandom_range(15), $urandom_range(31)));
         end else begin
            request_words.push_back(req_type'({$urandom, $urandom}));
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (request_words.size() != 0 || start || predicted_conversions.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (errors == 0 && predicted_conversions.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
